### design/tpia_pkg.sv
`default_nettype none

package tpia_pkg;

  localparam int TPIA_ID_WIDTH   = 32;
  localparam int TPIA_FREE_DEPTH = 64;

  localparam int OP_W      = 1;
  localparam int POOL_W    = 2;
  localparam int FIELD_W   = 32;
  localparam int NUM_POOLS = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [POOL_W-1:0] POOL_INODE = 2'd0;
  localparam logic [POOL_W-1:0] POOL_DIR   = 2'd1;
  localparam logic [POOL_W-1:0] POOL_DATA  = 2'd2;
  localparam logic [POOL_W-1:0] POOL_BAD   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_POOL  = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

endpackage

`default_nettype wire

### design/tpia_if.sv
`default_nettype none

interface tpia_req_if import tpia_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [POOL_W-1:0]   pool;
  logic [FIELD_W-1:0]  free_id;

  modport source (output valid, operation, pool, free_id, input ready);
  modport sink   (input valid, operation, pool, free_id, output ready);
endinterface

interface tpia_rsp_if import tpia_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  granted_id;
  status_t             status;

  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

`default_nettype wire

### design/tpia_ram.sv
`default_nettype none

module tpia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/three_pool_id_allocator_unit.sv
`default_nettype none

// Identifier allocator with three pools (inode, directory block, data block), each
// with a fresh-id counter and a FIFO free list held in its own RAM. One request is
// accepted every cycle unless stalled; it passes the request, then the response
// register, and the free-list RAM's registered read supplies the id on a list hit.
// State is ready right after reset: no RAM clearing pass. Status reports an
// unsupported pool, a full free list on free, or an exhausted counter on allocate;
// granted_id is zero whenever no id is handed out. Duplicate frees are not detected.
module three_pool_id_allocator_unit import tpia_pkg::*; #(
  parameter int ID_WIDTH   = TPIA_ID_WIDTH,
  parameter int FREE_DEPTH = TPIA_FREE_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tpia_req_if.sink   in_req,
  tpia_rsp_if.source out_rsp
);

  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);

  // request stage
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [POOL_W-1:0]   s1_pool_r;
  logic [ID_WIDTH-1:0] s1_id_r;

  // response stage
  logic                s2_valid_r;
  status_t             s2_status_r;
  logic                s2_from_list_r;
  logic [POOL_W-1:0]   s2_pool_r;
  logic [ID_WIDTH-1:0] s2_grant_r;

  // per-pool state
  logic [ID_WIDTH-1:0] ctr_r    [NUM_POOLS];
  logic [AW-1:0]       head_r   [NUM_POOLS];
  logic [CW-1:0]       cnt_r    [NUM_POOLS];
  logic [ID_WIDTH-1:0] ctr_nxt  [NUM_POOLS];
  logic [AW-1:0]       head_nxt [NUM_POOLS];
  logic [CW-1:0]       cnt_nxt  [NUM_POOLS];
  logic [ID_WIDTH-1:0] rd_data  [NUM_POOLS];

  logic                   s2_free;
  logic                   s1_commit;
  logic                   in_fire;
  logic [ID_WIDTH+FIELD_W-1:0] id_ext;

  logic [ID_WIDTH-1:0] cur_ctr;
  logic [AW-1:0]       cur_head;
  logic [CW-1:0]       cur_cnt;
  logic [AW-1:0]       head_inc;
  logic [CW:0]         tail_sum;
  logic [CW:0]         tail_wrap;
  logic [AW-1:0]       tail;
  status_t             st;
  logic                pop;
  logic                push;
  logic                ctr_inc;
  logic                ctr_dec;
  logic [ID_WIDTH-1:0] grant;

  logic [ID_WIDTH-1:0]         out_id;
  logic [ID_WIDTH+FIELD_W-1:0] out_ext;

  assign s2_free      = !s2_valid_r || out_rsp.ready;
  assign s1_commit    = s1_valid_r && s2_free;
  assign in_req.ready = !s1_valid_r || s2_free;
  assign in_fire      = in_req.valid && in_req.ready;
  assign id_ext       = {{ID_WIDTH{1'b0}}, in_req.free_id};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_req.operation;
      s1_pool_r <= in_req.pool;
      s1_id_r   <= id_ext[ID_WIDTH-1:0];
    end
  end

  always_comb begin
    case (s1_pool_r)
      POOL_INODE: begin
        cur_ctr = ctr_r[0]; cur_head = head_r[0]; cur_cnt = cnt_r[0];
      end
      POOL_DIR: begin
        cur_ctr = ctr_r[1]; cur_head = head_r[1]; cur_cnt = cnt_r[1];
      end
      POOL_DATA: begin
        cur_ctr = ctr_r[2]; cur_head = head_r[2]; cur_cnt = cnt_r[2];
      end
      default: begin
        cur_ctr = '0; cur_head = '0; cur_cnt = '0;
      end
    endcase
  end

  assign head_inc  = (cur_head == AW'(FREE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign tail_sum  = (CW+1)'(cur_head) + (CW+1)'(cur_cnt);
  assign tail_wrap = (tail_sum >= (CW+1)'(FREE_DEPTH)) ?
                     tail_sum - (CW+1)'(FREE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[AW-1:0];

  always_comb begin
    st      = ST_OK;
    pop     = 1'b0;
    push    = 1'b0;
    ctr_inc = 1'b0;
    ctr_dec = 1'b0;
    grant   = '0;
    if (s1_pool_r == POOL_BAD) begin
      st = ST_BAD_POOL;
    end else if (s1_op_r == OP_ALLOC) begin
      if (cur_cnt != '0) begin
        pop = 1'b1;
      end else if (cur_ctr == '1) begin
        st = ST_EXHAUSTED;
      end else begin
        grant   = cur_ctr;
        ctr_inc = 1'b1;
      end
    end else begin
      if (cur_ctr != '0 && s1_id_r == cur_ctr - 1'b1) begin
        ctr_dec = 1'b1;
      end else if (cur_cnt >= CW'(FREE_DEPTH)) begin
        st = ST_FULL;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      ctr_nxt[p]  = ctr_r[p];
      head_nxt[p] = head_r[p];
      cnt_nxt[p]  = cnt_r[p];
      if (s1_commit && s1_pool_r == POOL_W'(p)) begin
        if (ctr_inc) ctr_nxt[p] = cur_ctr + 1'b1;
        if (ctr_dec) ctr_nxt[p] = cur_ctr - 1'b1;
        if (pop) begin
          head_nxt[p] = head_inc;
          cnt_nxt[p]  = cur_cnt - 1'b1;
        end
        if (push) cnt_nxt[p] = cur_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        ctr_r[p]  <= (POOL_W'(p) == POOL_INODE) ? ID_WIDTH'(1) : '0;
        head_r[p] <= '0;
        cnt_r[p]  <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        ctr_r[p]  <= ctr_nxt[p];
        head_r[p] <= head_nxt[p];
        cnt_r[p]  <= cnt_nxt[p];
      end
    end
  end

  for (genvar g = 0; g < NUM_POOLS; g++) begin : g_pool
    logic sel;
    assign sel = s1_commit && (s1_pool_r == POOL_W'(g));

    tpia_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (FREE_DEPTH)
    ) u_free_list (
      .clk   (clk),
      .we    (sel && push),
      .waddr (tail),
      .wdata (s1_id_r),
      .re    (sel && pop),
      .raddr (cur_head),
      .rdata (rd_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_commit) begin
      s2_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      s2_status_r    <= st;
      s2_from_list_r <= pop;
      s2_pool_r      <= s1_pool_r;
      s2_grant_r     <= grant;
    end
  end

  always_comb begin
    out_id = s2_grant_r;
    if (s2_from_list_r) begin
      case (s2_pool_r)
        POOL_INODE: out_id = rd_data[0];
        POOL_DIR:   out_id = rd_data[1];
        POOL_DATA:  out_id = rd_data[2];
        default:    out_id = '0;
      endcase
    end
  end

  assign out_ext            = {{FIELD_W{1'b0}}, out_id};
  assign out_rsp.valid      = s2_valid_r;
  assign out_rsp.granted_id = out_ext[FIELD_W-1:0];
  assign out_rsp.status     = s2_status_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CW'(FREE_DEPTH) && cnt_r[1] <= CW'(FREE_DEPTH) &&
    cnt_r[2] <= CW'(FREE_DEPTH))
    else $error("free list count above depth");

  a_bad_pool_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    s1_commit && s1_pool_r == POOL_BAD |=>
      $stable(ctr_r[0]) && $stable(ctr_r[1]) && $stable(ctr_r[2]) &&
      $stable(cnt_r[0]) && $stable(cnt_r[1]) && $stable(cnt_r[2]))
    else $error("unsupported pool changed state");

  a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_rsp.ready |=> s2_valid_r)
    else $error("stalled response dropped");

  a_list_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_from_list_r |-> s2_status_r == ST_OK)
    else $error("list hit with error status");
`endif

endmodule

`default_nettype wire
